// ----- hw/rtl/knt_pkg.sv -----
package knt_pkg;

  localparam int VALUE_OUT_W = 31;
  localparam int LEN_OUT_W   = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    KIND_LPAREN  = 5'd0,
    KIND_RPAREN  = 5'd1,
    KIND_LBRACE  = 5'd2,
    KIND_RBRACE  = 5'd3,
    KIND_PLUS    = 5'd4,
    KIND_MINUS   = 5'd5,
    KIND_STAR    = 5'd6,
    KIND_SLASH   = 5'd7,
    KIND_PERCENT = 5'd8,
    KIND_LESS    = 5'd9,
    KIND_SEMI    = 5'd10,
    KIND_ASSIGN  = 5'd11,
    KIND_EOF     = 5'd12,
    KIND_NUMBER  = 5'd13,
    KIND_WHILE   = 5'd14,
    KIND_IF      = 5'd15,
    KIND_ELSE    = 5'd16,
    KIND_IDENT   = 5'd17,
    KIND_UNKNOWN = 5'd18
  } token_kind_t;

  typedef struct packed {
    token_kind_t            kind;
    logic [VALUE_OUT_W-1:0] value;
    logic [LEN_OUT_W-1:0]   len;
    logic                   last;
  } tok_t;

  // keyword candidate bits
  localparam int KW_WHILE = 0;
  localparam int KW_IF    = 1;
  localparam int KW_ELSE  = 2;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {" ", [8'd9:8'd13]};
  endfunction

  function automatic token_kind_t sym_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PERCENT;
      "<":     k = KIND_LESS;
      ";":     k = KIND_SEMI;
      "=":     k = KIND_ASSIGN;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // Which keywords still match with character c at position p (p of 7 = past all).
  function automatic logic [2:0] kw_hit(input logic [2:0] p, input logic [7:0] c);
    logic [2:0] h;
    h = 3'b000;
    case (p)
      3'd0: begin
        h[KW_WHILE] = (c == "w");
        h[KW_IF]    = (c == "i");
        h[KW_ELSE]  = (c == "e");
      end
      3'd1: begin
        h[KW_WHILE] = (c == "h");
        h[KW_IF]    = (c == "f");
        h[KW_ELSE]  = (c == "l");
      end
      3'd2: begin
        h[KW_WHILE] = (c == "i");
        h[KW_ELSE]  = (c == "s");
      end
      3'd3: begin
        h[KW_WHILE] = (c == "l");
        h[KW_ELSE]  = (c == "e");
      end
      3'd4: begin
        h[KW_WHILE] = (c == "e");
      end
      default: h = 3'b000;
    endcase
    return h;
  endfunction

endpackage

// ----- hw/rtl/knt_lexer.sv -----
module knt_lexer #(
  parameter int VALUE_WIDTH   = 31,
  parameter int MAX_IDENT_LEN = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output knt_pkg::tok_t tok0,
  output knt_pkg::tok_t tok1,
  output logic [1:0]  tok_cnt
);
  import knt_pkg::*;

  localparam int CNT_W = $clog2(MAX_IDENT_LEN + 1);
  localparam int PROD_W = VALUE_WIDTH + 4;
  localparam logic [PROD_W-1:0] VALUE_MAX = PROD_W'({VALUE_WIDTH{1'b1}});
  localparam logic [CNT_W-1:0] IDENT_MAX = CNT_W'(MAX_IDENT_LEN);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_NUMBER = 3'b010,
    MODE_IDENT  = 3'b100
  } lex_mode_t;

  lex_mode_t              mode_r, mode_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [2:0]             cand_r, cand_nxt;

  logic             c_digit, c_letter, c_space;
  logic             in_num, in_id, pend_valid;
  logic [PROD_W-1:0] acc_sum;
  logic [VALUE_WIDTH-1:0] acc_step;
  logic [2:0]       p_small;
  logic [2:0]       cand_step;
  logic [CNT_W-1:0] cnt_step;
  token_kind_t      id_kind;
  tok_t             pend_tok, new_tok;
  logic             emit_pend, emit_new;

  assign c_digit  = is_digit(char_code);
  assign c_letter = is_letter(char_code);
  assign c_space  = is_space(char_code);

  always_comb begin
    in_num = 1'b0;
    in_id  = 1'b0;
    case (mode_r)
      MODE_NUMBER: in_num = 1'b1;
      MODE_IDENT:  in_id  = 1'b1;
      default: begin
        in_num = 1'b0;
        in_id  = 1'b0;
      end
    endcase
  end
  assign pend_valid = in_num | in_id;

  // acc*10 + digit as shift-add, saturate on overflow
  assign acc_sum = (PROD_W'(acc_r) << 3) + (PROD_W'(acc_r) << 1) + PROD_W'(char_code[3:0]);
  assign acc_step = (acc_sum > VALUE_MAX) ? {VALUE_WIDTH{1'b1}} : acc_sum[VALUE_WIDTH-1:0];

  assign p_small   = (cnt_r > CNT_W'(7)) ? 3'd7 : cnt_r[2:0];
  assign cand_step = cand_r & kw_hit(p_small, char_code);
  assign cnt_step  = (cnt_r < IDENT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    id_kind = KIND_IDENT;
    if (cand_r[KW_WHILE] && cnt_r == CNT_W'(5)) id_kind = KIND_WHILE;
    if (cand_r[KW_IF]    && cnt_r == CNT_W'(2)) id_kind = KIND_IF;
    if (cand_r[KW_ELSE]  && cnt_r == CNT_W'(4)) id_kind = KIND_ELSE;
  end

  always_comb begin
    pend_tok = '0;
    if (in_num) begin
      pend_tok.kind  = KIND_NUMBER;
      pend_tok.value = VALUE_OUT_W'(acc_r);
    end else begin
      pend_tok.kind = id_kind;
      pend_tok.len  = LEN_OUT_W'(cnt_r);
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    cand_nxt  = cand_r;
    emit_pend = 1'b0;
    emit_new  = 1'b0;
    new_tok   = '0;
    if (end_of_input) begin
      emit_pend    = pend_valid;
      emit_new     = 1'b1;
      new_tok.kind = KIND_EOF;
      mode_nxt     = MODE_IDLE;
      acc_nxt      = '0;
      cnt_nxt      = '0;
      cand_nxt     = 3'b111;
    end else if (in_num && c_digit) begin
      acc_nxt = acc_step;
    end else if (in_id && (c_digit || c_letter)) begin
      cnt_nxt  = cnt_step;
      cand_nxt = cand_step;
    end else begin
      emit_pend = pend_valid;
      mode_nxt  = MODE_IDLE;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      cand_nxt  = 3'b111;
      if (c_digit) begin
        mode_nxt = MODE_NUMBER;
        acc_nxt  = VALUE_WIDTH'(char_code[3:0]);
      end else if (c_letter) begin
        mode_nxt = MODE_IDENT;
        cnt_nxt  = CNT_W'(1);
        cand_nxt = kw_hit(3'd0, char_code);
      end else if (!c_space) begin
        emit_new     = 1'b1;
        new_tok.kind = sym_kind(char_code);
      end
    end
  end

  always_comb begin
    tok1      = new_tok;
    tok1.last = 1'b1;
    tok0      = emit_pend ? pend_tok : new_tok;
    tok0.last = !(emit_pend && emit_new);
    tok_cnt   = {1'b0, emit_pend} + {1'b0, emit_new};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      cand_r <= 3'b111;
    end else if (step) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      cand_r <= cand_nxt;
    end
  end

endmodule

// ----- hw/rtl/knt_outq.sv -----
module knt_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  knt_pkg::tok_t wr0,
  input  knt_pkg::tok_t wr1,
  input  logic          pop,
  output knt_pkg::tok_t rd,
  output logic          not_empty,
  output logic          room2
);
  import knt_pkg::*;

  tok_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign rd        = mem_r[rd_ptr_r];
  // room for two words counting this cycle's pop
  assign room2 = ({1'b0, cnt_r} <= (QCNT_W + 1)'(QUEUE_DEPTH - 2) + (QCNT_W + 1)'(do_pop));

  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
  assign cnt_nxt    = cnt_r + QCNT_W'(push_cnt) - QCNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= wr0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_r + QPTR_W'(1)] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("output queue count above depth");
`endif

endmodule

// ----- hw/rtl/keyword_number_tokenizer.sv -----
// channel  dir  tdata                           tlast          tuser
// in_      in   [7:0] char_code                 end_of_input   -
// out_     out  [30:0] value [38:31] length     last_of_item   [4:0] kind
//
// One character word is taken per cycle; an input register feeds the lexer
// and each word yields zero, one or two token words into a 4-word queue.
// Token output runs at one word per cycle while out_tready is high, so words
// giving two tokens throttle input to the output rate. Input stalls only
// when the queue lacks room for two words. Reset (rst_n low, synchronous)
// returns the lexer to idle between tokens and empties the queue.
module keyword_number_tokenizer #(
  parameter int VALUE_WIDTH   = 31,
  parameter int MAX_IDENT_LEN = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [30:0] number_value, [38:31] ident_length
  output logic [4:0]  out_tuser,  // [4:0] token_kind
  output logic        out_tlast   // last_of_item
);
  import knt_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_char_r;
  logic       in_eof_r;
  logic       in_accept, adv;
  tok_t       tok0, tok1, rd;
  logic [1:0] tok_cnt;
  logic       q_not_empty, q_room2;

  assign adv       = in_valid_r && q_room2;
  assign in_tready = !in_valid_r || adv;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) in_valid_nxt = 1'b1;
    else if (adv)  in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_char_r <= in_tdata;
      in_eof_r  <= in_tlast;
    end
  end

  knt_lexer #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .MAX_IDENT_LEN (MAX_IDENT_LEN)
  ) u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .char_code    (in_char_r),
    .end_of_input (in_eof_r),
    .tok0         (tok0),
    .tok1         (tok1),
    .tok_cnt      (tok_cnt)
  );

  knt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (adv ? tok_cnt : 2'd0),
    .wr0       (tok0),
    .wr1       (tok1),
    .pop       (out_tready),
    .rd        (rd),
    .not_empty (q_not_empty),
    .room2     (q_room2)
  );

  assign out_tvalid = q_not_empty;
  assign out_tdata  = {1'b0, rd.len, rd.value};
  assign out_tuser  = rd.kind;
  assign out_tlast  = rd.last;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_char_r) && $stable(in_eof_r))
    else $error("held input word changed or dropped");

  a_eof_token: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_eof_r |-> tok_cnt != 2'd0)
    else $error("end of input produced no token");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("second token of a word missing");
`endif

endmodule

// ----- verif/token_stream_checker.sv -----
module token_stream_checker #(
  parameter int VALUE_BITS = 31,
  parameter int LEN_CAP    = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [4:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding,
  output int          tokens_seen
);
  import knt_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_WORD
  } scan_mode_t;

  localparam longint unsigned NUM_CEIL = (64'd1 << VALUE_BITS) - 64'd1;

  string       kw_spell [3] = '{"while", "if", "else"};
  token_kind_t kw_token [3] = '{KIND_WHILE, KIND_IF, KIND_ELSE};

  scan_mode_t      scan_mode;
  longint unsigned num_acc;
  int              word_len;
  logic [2:0]      kw_alive;
  tok_t            token_fifo [$];

  function automatic bit char_is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit char_is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit char_is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic token_kind_t symbol_token(input logic [7:0] c);
    case (c)
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      "/":     return KIND_SLASH;
      "%":     return KIND_PERCENT;
      "<":     return KIND_LESS;
      ";":     return KIND_SEMI;
      "=":     return KIND_ASSIGN;
      default: return KIND_UNKNOWN;
    endcase
  endfunction

  task automatic clear_scan();
    scan_mode = SCAN_IDLE;
    num_acc   = 0;
    word_len  = 0;
    kw_alive  = 3'b111;
  endtask

  task automatic push_token(input token_kind_t kind, input longint unsigned value,
                            input int len);
    tok_t t;
    t.kind  = kind;
    t.value = value[VALUE_OUT_W-1:0];
    t.len   = len[LEN_OUT_W-1:0];
    t.last  = 1'b0;
    token_fifo.push_back(t);
  endtask

  // emit whatever number or word is in progress, back to idle
  task automatic close_pending();
    token_kind_t kind;
    if (scan_mode == SCAN_NUMBER) begin
      push_token(KIND_NUMBER, num_acc, 0);
    end else if (scan_mode == SCAN_WORD) begin
      kind = KIND_IDENT;
      for (int k = 0; k < 3; k++) begin
        if (kw_alive[k] && word_len == kw_spell[k].len()) kind = kw_token[k];
      end
      push_token(kind, 0, word_len);
    end
    clear_scan();
  endtask

  task automatic add_digit(input logic [7:0] c);
    longint unsigned d;
    d = c - "0";
    if (num_acc > (NUM_CEIL - d) / 10) num_acc = NUM_CEIL;
    else num_acc = num_acc * 10 + d;
  endtask

  task automatic add_letter(input logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (word_len >= kw_spell[k].len()) kw_alive[k] = 1'b0;
      else if (kw_spell[k][word_len] != c) kw_alive[k] = 1'b0;
    end
    if (word_len < LEN_CAP) word_len++;
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic eoi);
    int start_size;
    start_size = token_fifo.size();
    if (eoi) begin
      close_pending();
      push_token(KIND_EOF, 0, 0);
    end else if (scan_mode == SCAN_NUMBER && char_is_digit(c)) begin
      add_digit(c);
    end else if (scan_mode == SCAN_WORD && (char_is_digit(c) || char_is_letter(c))) begin
      add_letter(c);
    end else begin
      close_pending();
      if (char_is_digit(c)) begin
        scan_mode = SCAN_NUMBER;
        add_digit(c);
      end else if (char_is_letter(c)) begin
        scan_mode = SCAN_WORD;
        add_letter(c);
      end else if (!char_is_blank(c)) begin
        push_token(symbol_token(c), 0, 0);
      end
    end
    if (token_fifo.size() > start_size) token_fifo[token_fifo.size() - 1].last = 1'b1;
  endtask

  task automatic check_token();
    tok_t got;
    tok_t want;
    got.kind  = token_kind_t'(out_tuser);
    got.value = out_tdata[30:0];
    got.len   = out_tdata[38:31];
    got.last  = out_tlast;
    tokens_seen++;
    if (token_fifo.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected token word: kind %0d value %0d len %0d last %0b",
                 got.kind, got.value, got.len, got.last);
    end else begin
      want = token_fifo.pop_front();
      if (got.kind !== want.kind || got.value !== want.value || got.len !== want.len ||
          got.last !== want.last || out_tdata[39] !== 1'b0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"token mismatch: expected kind %0d value %0d len %0d last %0b,",
                    " got kind %0d value %0d len %0d last %0b pad %b"},
                   want.kind, want.value, want.len, want.last,
                   got.kind, got.value, got.len, got.last, out_tdata[39]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      token_fifo.delete();
      mismatches  = 0;
      tokens_seen = 0;
    end else begin
      // a token word never leaves in the cycle its character is taken,
      // so popping first is safe
      if (out_tvalid && out_tready) check_token();
      if (in_tvalid && in_tready) predict_tokens(in_tdata, in_tlast);
    end
    outstanding = token_fifo.size();
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int tokens_seen;

  int items_sent  = 0;
  int words_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  int         rx_left  = 0;
  int         rx_style = 0;
  logic [7:0] rx_mask  = 8'hff;

  string overflow_edges [4] = '{"2147483647", "2147483648", "214748364", "21474836479"};
  string word_picks [8]     = '{"while", "if", "else", "whil", "iff", "elsee", "el", "While"};

  always #10 clk = ~clk;

  keyword_number_tokenizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  token_stream_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .tokens_seen (tokens_seen)
  );

  // receiver: stretches of always-ready, random, sparse, masked and mostly-ready patterns
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 4);
      rx_left  <= $urandom_range(8, 80);
      rx_mask  <= 8'($urandom);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      3:       out_tready <= rx_mask[rx_left[2:0]];
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d tokens still expected", outstanding);
      $display("[keyword_number_tokenizer] ERROR");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge after the word is taken
  task automatic send_word(input logic [7:0] c, input logic eoi);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      in_tdata  = 8'($urandom);
      in_tlast  = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = eoi;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    words_sent++;
    if (eoi || !(c == " " || (c >= 8'd9 && c <= 8'd13))) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'("0" + $urandom_range(0, 9));
    return pick_letter();
  endfunction

  task automatic send_long_word(input int len);
    send_word(pick_letter(), 1'b0);
    for (int i = 1; i < len; i++) send_word(pick_alnum(), 1'b0);
  endtask

  task automatic random_fragment();
    string syms;
    int    pick;
    int    len;
    syms = "(){}+-*/%<;=";
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if ($urandom_range(0, 2) == 0) begin
        send_text(word_picks[$urandom_range(0, 7)]);
      end else begin
        len = $urandom_range(1, 8);
        send_long_word(len);
      end
    end else if (pick < 50) begin
      if ($urandom_range(0, 9) == 0) begin
        send_text(overflow_edges[$urandom_range(0, 3)]);
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 30) :
              ($urandom_range(0, 5) == 0)  ? $urandom_range(9, 12)  : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
    end else if (pick < 70) begin
      send_word(syms[$urandom_range(0, 11)], 1'b0);
    end else if (pick < 85) begin
      if ($urandom_range(0, 5) == 0) send_word(" ", 1'b0);
      else send_word(8'($urandom_range(9, 13)), 1'b0);
    end else if (pick < 95) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int random_start;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    in_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every symbol, keywords ended by whitespace, pending word and number at end
    send_text("(){}+-*/%<;=");
    send_text("if\telse\f");
    send_text("while");
    send_word(8'd0, 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h00, 1'b0);
    send_text("7");
    send_word(8'hff, 1'b1);
    send_word(8'h00, 1'b1);

    // identifier length saturation: one character past the cap
    send_long_word(256);
    send_word("\n", 1'b0);

    random_start = words_sent;
    while (words_sent - random_start < RANDOM_ITEMS) random_fragment();
    send_word(8'd0, 1'b1);

    in_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (20) @(posedge clk);

    $display("sent %0d character words (%0d non-blank), checked %0d token words",
             words_sent, items_sent, tokens_seen);
    $display("covered symbols, keywords, number and length saturation, end-of-input flushes");
    if (mismatches == 0) begin
      $display("[keyword_number_tokenizer] OK");
    end else begin
      $display("[keyword_number_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
